FILE: sv/ole_pkg.sv
package ole_pkg;

	// Request codes, carried on s_axis_tuser
	localparam logic [2:0] REQ_INSERT   = 3'd0;
	localparam logic [2:0] REQ_APPEND   = 3'd1;
	localparam logic [2:0] REQ_DEL_POS  = 3'd2;
	localparam logic [2:0] REQ_DEL_LAST = 3'd3;
	localparam logic [2:0] REQ_SEARCH   = 3'd4;
	localparam logic [2:0] REQ_REVERSE  = 3'd5;

	// Result status codes
	localparam logic [2:0] ST_DONE   = 3'd0;
	localparam logic [2:0] ST_BADPOS = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_MISS   = 3'd4;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		RD_IDX_M1,
		RD_IDX_P1,
		RD_IDX,
		RD_HI
	} ole_rsel_t;

	typedef enum logic [1:0] {
		WR_IDX_RD,
		WR_AT_KEY,
		WR_HI_TMP
	} ole_wsel_t;

	typedef struct packed {
		logic       ld_req;
		logic       rd;
		ole_rsel_t  rsel;
		logic       wr;
		ole_wsel_t  wsel;
		logic       idx_inc;
		logic       idx_dec;
		logic       hi_dec;
		logic       save_tmp;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		logic [2:0] res_status;
		logic       res_found;
	} ole_cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       cnt_zero;
		logic       cnt_full;
		logic       pos_bad_ins;
		logic       pos_bad_del;
		logic       idx_gt_at;
		logic       del_more;
		logic       srch_more;
		logic       match;
		logic       rev_more;
		logic       out_free;
	} ole_stat_t;

endpackage

FILE: sv/ole_datapath.sv
module ole_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ole_pkg::ole_cmd_t           cmd,
	output ole_pkg::ole_stat_t          stat,
	// s_axis_tdata: position[7:0], value[39:8]
	input  logic [ole_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// s_axis_tuser: req_type[2:0]
	input  logic [2:0]                  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// m_axis_tdata: status[2:0], found_position[7:3], entry_count[12:8], zero fill
	output logic [ole_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ole_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_data_q;
	logic [31:0]   tmp_q;
	logic [31:0]   key_q;
	logic [2:0]    req_q;
	logic [7:0]    pos_q;
	logic [CW-1:0] at_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [4:0]    out_found_q;
	logic [4:0]    out_count_q;

	logic [2:0]    in_req;
	logic [7:0]    in_pos;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] at_d;
	logic [CW-1:0] raddr;
	logic [CW-1:0] waddr;
	logic [31:0]   wdata;
	logic [CW:0]   idx_p1;
	logic [8:0]    pos_ext;
	logic [8:0]    cnt_ext;

	assign in_req  = s_axis_tuser;
	assign in_pos  = s_axis_tdata[7:0];
	assign pos_m1  = CW'(in_pos - 8'd1);
	assign at_d    = (in_req == REQ_APPEND) ? count_q : pos_m1;
	assign idx_p1  = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign pos_ext = {1'b0, pos_q};
	assign cnt_ext = 9'(count_q);

	always_comb begin
		stat.req         = req_q;
		stat.cnt_zero    = (count_q == '0);
		stat.cnt_full    = (count_q >= CW'(CAPACITY));
		stat.pos_bad_ins = (pos_q == 8'd0) || (pos_ext > cnt_ext + 9'd1);
		stat.pos_bad_del = (pos_q == 8'd0) || (pos_ext > cnt_ext);
		stat.idx_gt_at   = (idx_q > at_q);
		stat.del_more    = (idx_p1 < {1'b0, count_q});
		stat.srch_more   = (idx_q < count_q);
		stat.match       = (rd_data_q == key_q);
		stat.rev_more    = (idx_q < hi_q);
		stat.out_free    = !out_valid_q || m_axis_tready;
	end

	always_comb begin
		case (cmd.rsel)
			RD_IDX_M1: raddr = idx_q - CW'(1);
			RD_IDX_P1: raddr = idx_p1[CW-1:0];
			RD_IDX:    raddr = idx_q;
			RD_HI:     raddr = hi_q;
			default:   raddr = idx_q;
		endcase
	end

	always_comb begin
		case (cmd.wsel)
			WR_IDX_RD: begin
				waddr = idx_q;
				wdata = rd_data_q;
			end
			WR_AT_KEY: begin
				waddr = at_q;
				wdata = key_q;
			end
			WR_HI_TMP: begin
				waddr = hi_q;
				wdata = tmp_q;
			end
			default: begin
				waddr = idx_q;
				wdata = rd_data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[raddr[AW-1:0]];
		end
	end

	// walk pointers and request capture
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_q <= in_req;
			pos_q <= in_pos;
			key_q <= s_axis_tdata[39:8];
			at_q  <= at_d;
			hi_q  <= (count_q == '0) ? '0 : count_q - CW'(1);
			case (in_req)
				REQ_INSERT, REQ_APPEND: idx_q <= count_q;
				REQ_DEL_POS:            idx_q <= pos_m1;
				default:                idx_q <= '0;
			endcase
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= idx_p1[CW-1:0];
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.hi_dec) begin
				hi_q <= hi_q - CW'(1);
			end
		end
		if (cmd.save_tmp) begin
			tmp_q <= rd_data_q;
		end
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_found_q  <= cmd.res_found ? 5'(idx_p1) : 5'd0;
			out_count_q  <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_count_q, out_found_q, out_status_q};

endmodule

FILE: sv/ole_ctrl.sv
module ole_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  ole_pkg::ole_stat_t stat,
	output ole_pkg::ole_cmd_t  cmd
);
	import ole_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_SH_CHK  = 4'd2;
	localparam logic [3:0] S_SH_WR   = 4'd3;
	localparam logic [3:0] S_INS_WR  = 4'd4;
	localparam logic [3:0] S_DL_CHK  = 4'd5;
	localparam logic [3:0] S_DL_WR   = 4'd6;
	localparam logic [3:0] S_SR_CHK  = 4'd7;
	localparam logic [3:0] S_SR_CMP  = 4'd8;
	localparam logic [3:0] S_RV_CHK  = 4'd9;
	localparam logic [3:0] S_RV_RDHI = 4'd10;
	localparam logic [3:0] S_RV_WRLO = 4'd11;
	localparam logic [3:0] S_RV_WRHI = 4'd12;
	localparam logic [3:0] S_RESP    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [2:0] status_q;
	logic [2:0] status_d;
	logic       found_q;
	logic       found_d;

	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		found_d  = found_q;
		cmd      = '0;
		cmd.rsel = RD_IDX;
		cmd.wsel = WR_IDX_RD;
		cmd.res_status = status_q;
		cmd.res_found  = found_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.ld_req = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d = ST_DONE;
				found_d  = 1'b0;
				state_d  = S_RESP;
				case (stat.req)
					REQ_INSERT: begin
						if (stat.pos_bad_ins) begin
							status_d = ST_BADPOS;
						end else if (stat.cnt_full) begin
							status_d = ST_FULL;
						end else begin
							state_d = S_SH_CHK;
						end
					end
					REQ_APPEND: begin
						if (stat.cnt_full) begin
							status_d = ST_FULL;
						end else begin
							state_d = S_SH_CHK;
						end
					end
					REQ_DEL_POS: begin
						if (stat.cnt_zero) begin
							status_d = ST_EMPTY;
						end else if (stat.pos_bad_del) begin
							status_d = ST_BADPOS;
						end else begin
							state_d = S_DL_CHK;
						end
					end
					REQ_DEL_LAST: begin
						if (stat.cnt_zero) begin
							status_d = ST_EMPTY;
						end else begin
							cmd.cnt_dec = 1'b1;
						end
					end
					REQ_SEARCH:  state_d = S_SR_CHK;
					REQ_REVERSE: state_d = S_RV_CHK;
					default:     state_d = S_RESP;
				endcase
			end
			// open a gap: move entries up one slot, from the tail down
			S_SH_CHK: begin
				if (stat.idx_gt_at) begin
					cmd.rd   = 1'b1;
					cmd.rsel = RD_IDX_M1;
					state_d  = S_SH_WR;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr      = 1'b1;
				cmd.wsel    = WR_IDX_RD;
				cmd.idx_dec = 1'b1;
				state_d     = S_SH_CHK;
			end
			S_INS_WR: begin
				cmd.wr      = 1'b1;
				cmd.wsel    = WR_AT_KEY;
				cmd.cnt_inc = 1'b1;
				state_d     = S_RESP;
			end
			// close a gap: move entries down one slot
			S_DL_CHK: begin
				if (stat.del_more) begin
					cmd.rd   = 1'b1;
					cmd.rsel = RD_IDX_P1;
					state_d  = S_DL_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_DL_WR: begin
				cmd.wr      = 1'b1;
				cmd.wsel    = WR_IDX_RD;
				cmd.idx_inc = 1'b1;
				state_d     = S_DL_CHK;
			end
			S_SR_CHK: begin
				if (stat.srch_more) begin
					cmd.rd   = 1'b1;
					cmd.rsel = RD_IDX;
					state_d  = S_SR_CMP;
				end else begin
					status_d = ST_MISS;
					state_d  = S_RESP;
				end
			end
			S_SR_CMP: begin
				if (stat.match) begin
					found_d = 1'b1;
					state_d = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SR_CHK;
				end
			end
			// swap one pair: read low, read high, write both
			S_RV_CHK: begin
				if (stat.rev_more) begin
					cmd.rd   = 1'b1;
					cmd.rsel = RD_IDX;
					state_d  = S_RV_RDHI;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RV_RDHI: begin
				cmd.rd       = 1'b1;
				cmd.rsel     = RD_HI;
				cmd.save_tmp = 1'b1;
				state_d      = S_RV_WRLO;
			end
			S_RV_WRLO: begin
				cmd.wr   = 1'b1;
				cmd.wsel = WR_IDX_RD;
				state_d  = S_RV_WRHI;
			end
			S_RV_WRHI: begin
				cmd.wr      = 1'b1;
				cmd.wsel    = WR_HI_TMP;
				cmd.idx_inc = 1'b1;
				cmd.hi_dec  = 1'b1;
				state_d     = S_RV_CHK;
			end
			S_RESP: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			found_q  <= found_d;
		end
	end

endmodule

FILE: sv/ordered_list_engine_core.sv
// Ordered list of up to CAPACITY signed 32-bit values, kept packed in a
// single-port-read memory. One request item on the s_axis channel
// (req_type on tuser; position and value on tdata) gives exactly one
// result item on the m_axis channel (status, found_position, entry_count).
// Requests are handled one at a time: s_axis_tready is high only while the
// controller is idle. Rejected requests, delete last and unused request
// codes go from the decode state straight to the result state; a search or
// reverse with nothing to walk passes through its check state first. The
// longest items are a search that misses on a full list and a full reverse.
// Shifting reads an entry and then writes it one slot over, searching reads
// an entry and then compares it, and a reverse reads the low entry, reads the
// high one and writes both, all through the memory's one read port. The next
// item can be accepted in the cycle after a result is loaded. The result sits
// in an output register, so the next item is accepted even while the receiver
// stalls; a new result waits in the controller until that register is taken.
// Reset clears the entry count and the output valid; the list memory needs no
// clearing, as only entries below the count are ever read.
module ordered_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// position[7:0], value[39:8]
	input  logic [ole_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status[2:0], found_position[7:3], entry_count[12:8], zero fill
	output logic [ole_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ole_pkg::*;

	ole_cmd_t  cmd;
	ole_stat_t stat;

	ole_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	ole_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

FILE: sv/ole_checker.sv
module ole_checker #(
	parameter int CAPACITY = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ole_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ole_pkg::*;

	// one request at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on two cycles in a row");

	a_found_means_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[7:3] != 5'd0) |-> (m_axis_tdata[2:0] == ST_DONE))
		else $error("found position given with a failure status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == ST_FULL) |->
		(m_axis_tdata[12:8] == 5'(CAPACITY)))
		else $error("full status with list not at capacity");

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind ordered_list_engine_core ole_checker #(
	.CAPACITY (CAPACITY)
) u_ole_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
